FILE: rtl/oilws_pkg.sv
// Shared constants, codes and types for the ordered item list with weight sum.
`default_nettype none
package oilws_pkg;

    localparam int CAPACITY_DEF    = 32;
    localparam int ID_BITS_DEF     = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int FUNC_W   = 1;
    localparam int ID_W     = 16;
    localparam int WEIGHT_W = 16;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;
    localparam int TOTAL_W  = 21;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic load;
        logic shift;
        logic hit;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/oilws_if.sv
// Request and response channel interfaces of the ordered item list.
`default_nettype none
interface oilws_req_if;
    logic                                valid;
    logic                                ready;
    logic [oilws_pkg::FUNC_W-1:0]        func;
    logic [oilws_pkg::ID_W-1:0]          item_id;
    logic [oilws_pkg::WEIGHT_W-1:0]      item_weight;
    logic [oilws_pkg::POS_W-1:0]         position;

    modport source (output valid, func, item_id, item_weight, position, input ready);
    modport sink   (input valid, func, item_id, item_weight, position, output ready);
endinterface

interface oilws_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [oilws_pkg::STATUS_W-1:0]      status;
    logic [oilws_pkg::ID_W-1:0]          removed_id;
    logic [oilws_pkg::WEIGHT_W-1:0]      removed_weight;
    logic [oilws_pkg::COUNT_W-1:0]       item_count;
    logic [oilws_pkg::TOTAL_W-1:0]       total_weight;

    modport source (output valid, status, removed_id, removed_weight, item_count,
                    total_weight, input ready);
    modport sink   (input valid, status, removed_id, removed_weight, item_count,
                    total_weight, output ready);
endinterface
`default_nettype wire

FILE: rtl/oilws_cell.sv
// One list cell: holds an entry, loads a new one or takes its right neighbor's.
`default_nettype none
module oilws_cell #(
    parameter int ID_BITS     = oilws_pkg::ID_BITS_DEF,
    parameter int WEIGHT_BITS = oilws_pkg::WEIGHT_BITS_DEF
) (
    input  wire                          clk,
    input  wire  oilws_pkg::cell_ctrl_t  ctrl,
    input  wire  [ID_BITS-1:0]           new_id,
    input  wire  [WEIGHT_BITS-1:0]       new_weight,
    input  wire  [ID_BITS-1:0]           nbr_id,
    input  wire  [WEIGHT_BITS-1:0]       nbr_weight,
    output logic [ID_BITS-1:0]           id,
    output logic [WEIGHT_BITS-1:0]       weight,
    output logic [ID_BITS-1:0]           rd_id,
    output logic [WEIGHT_BITS-1:0]       rd_weight
);

    logic [ID_BITS-1:0]     id_reg,     id_next;
    logic [WEIGHT_BITS-1:0] weight_reg, weight_next;

    always_comb
    begin
        id_next     = id_reg;
        weight_next = weight_reg;
        if (ctrl.load)
        begin
            id_next     = new_id;
            weight_next = new_weight;
        end
        else if (ctrl.shift)
        begin
            id_next     = nbr_id;
            weight_next = nbr_weight;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        weight_reg <= weight_next;
    end

    assign id        = id_reg;
    assign weight    = weight_reg;
    assign rd_id     = ctrl.hit ? id_reg : '0;
    assign rd_weight = ctrl.hit ? weight_reg : '0;

endmodule
`default_nettype wire

FILE: rtl/ordered_item_list_with_weight_sum_unit.sv
// Top level: ordered item list built as a row of shifting cells, with count and weight sum.
// The response word is registered and valid in the cycle after its request word is accepted.
// Throughput: one request word per cycle unless a pending response is stalled; each word is
// finished in the cycle it is accepted, the gap closes in one shift of the cells above it.
// The response register lets a new word in while the previous response is taken.
// Reset clears count, weight sum and response valid; cell contents stay undefined.
`default_nettype none
module ordered_item_list_with_weight_sum_unit #(
    parameter int CAPACITY    = oilws_pkg::CAPACITY_DEF,
    parameter int ID_BITS     = oilws_pkg::ID_BITS_DEF,
    parameter int WEIGHT_BITS = oilws_pkg::WEIGHT_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    oilws_req_if.sink   req,
    oilws_rsp_if.source rsp
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PCW = (CW > oilws_pkg::POS_W) ? CW : oilws_pkg::POS_W;
    localparam int SW  = WEIGHT_BITS + CW;
    localparam int TW  = (SW > oilws_pkg::TOTAL_W) ? SW : oilws_pkg::TOTAL_W;

    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] sum_reg,   sum_next;

    logic                                  rsp_valid_reg, rsp_valid_next;
    logic [oilws_pkg::STATUS_W-1:0]        status_reg,    status_next;
    logic [oilws_pkg::ID_W-1:0]            rid_reg,       rid_next;
    logic [oilws_pkg::WEIGHT_W-1:0]        rwt_reg,       rwt_next;
    logic [oilws_pkg::COUNT_W-1:0]         cnt_out_reg,   cnt_out_next;
    logic [oilws_pkg::TOTAL_W-1:0]         total_reg,     total_next;

    logic                   accept;
    logic                   is_remove;
    logic                   full;
    logic                   append_ok;
    logic                   remove_ok;
    logic [PCW-1:0]         pos_x;
    logic [PCW-1:0]         cnt_x;
    logic [ID_BITS-1:0]     new_id;
    logic [WEIGHT_BITS-1:0] new_weight;
    logic [ID_BITS-1:0]     rm_id;
    logic [WEIGHT_BITS-1:0] rm_weight;
    logic [TW-1:0]          sum_x;
    logic [CAPACITY-1:0]    load_vec;

    oilws_pkg::cell_ctrl_t  ctrl_a      [CAPACITY];
    logic [ID_BITS-1:0]     id_a        [CAPACITY];
    logic [WEIGHT_BITS-1:0] weight_a    [CAPACITY];
    logic [ID_BITS-1:0]     nbr_id_a    [CAPACITY];
    logic [WEIGHT_BITS-1:0] nbr_weight_a[CAPACITY];
    logic [ID_BITS-1:0]     rd_id_a     [CAPACITY];
    logic [WEIGHT_BITS-1:0] rd_weight_a [CAPACITY];

    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign accept     = req.valid && req.ready;
    assign is_remove  = (req.func == oilws_pkg::FUNC_REMOVE);
    assign full       = (count_reg == CW'(CAPACITY));
    assign pos_x      = PCW'(req.position);
    assign cnt_x      = PCW'(count_reg);
    assign append_ok  = !is_remove && !full;
    assign remove_ok  = is_remove && (pos_x < cnt_x);
    assign new_id     = ID_BITS'(req.item_id);
    assign new_weight = WEIGHT_BITS'(req.item_weight);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign ctrl_a[i].load  = accept && append_ok && (count_reg == CW'(i));
        assign ctrl_a[i].shift = accept && remove_ok && (PCW'(i) >= pos_x);
        assign ctrl_a[i].hit   = (PCW'(i) == pos_x);
        assign load_vec[i]     = ctrl_a[i].load;

        if (i == CAPACITY - 1)
        begin : g_last
            assign nbr_id_a[i]     = '0;
            assign nbr_weight_a[i] = '0;
        end
        else
        begin : g_mid
            assign nbr_id_a[i]     = id_a[i+1];
            assign nbr_weight_a[i] = weight_a[i+1];
        end

        oilws_cell #(
            .ID_BITS     (ID_BITS),
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl_a[i]),
            .new_id     (new_id),
            .new_weight (new_weight),
            .nbr_id     (nbr_id_a[i]),
            .nbr_weight (nbr_weight_a[i]),
            .id         (id_a[i]),
            .weight     (weight_a[i]),
            .rd_id      (rd_id_a[i]),
            .rd_weight  (rd_weight_a[i])
        );
    end

    always_comb
    begin
        rm_id     = '0;
        rm_weight = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            rm_id     = rm_id | rd_id_a[k];
            rm_weight = rm_weight | rd_weight_a[k];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (accept && append_ok)
        begin
            count_next = count_reg + CW'(1);
            sum_next   = sum_reg + SW'(new_weight);
        end
        else if (accept && remove_ok)
        begin
            count_next = count_reg - CW'(1);
            sum_next   = sum_reg - SW'(rm_weight);
        end
    end

    assign sum_x = TW'(sum_next);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        rid_next       = rid_reg;
        rwt_next       = rwt_reg;
        cnt_out_next   = cnt_out_reg;
        total_next     = total_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            if (is_remove)
            begin
                status_next = remove_ok ? oilws_pkg::ST_DONE : oilws_pkg::ST_BAD_INDEX;
            end
            else
            begin
                status_next = append_ok ? oilws_pkg::ST_DONE : oilws_pkg::ST_FULL;
            end
            rid_next     = remove_ok ? oilws_pkg::ID_W'(rm_id) : '0;
            rwt_next     = remove_ok ? oilws_pkg::WEIGHT_W'(rm_weight) : '0;
            cnt_out_next = oilws_pkg::COUNT_W'(count_next);
            total_next   = (sum_x > TW'(oilws_pkg::TOTAL_MAX)) ? oilws_pkg::TOTAL_MAX
                                                               : oilws_pkg::TOTAL_W'(sum_x);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        rid_reg     <= rid_next;
        rwt_reg     <= rwt_next;
        cnt_out_reg <= cnt_out_next;
        total_reg   <= total_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.removed_id     = rid_reg;
    assign rsp.removed_weight = rwt_reg;
    assign rsp.item_count     = cnt_out_reg;
    assign rsp.total_weight   = total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !accept)
        else $error("request taken while response stalled");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(load_vec))
        else $error("more than one cell loaded");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("no response after accepted request");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && remove_ok) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("count not decremented on removal");

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the ordered item list: random handshakes, scoreboard, watchdog.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS   = 1850;
    localparam int PHASE_WORDS    = 100;
    localparam int SQUEEZE_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_t;

    typedef struct packed {
        logic [oilws_pkg::STATUS_W-1:0] status;
        logic [oilws_pkg::ID_W-1:0]     removed_id;
        logic [oilws_pkg::WEIGHT_W-1:0] removed_weight;
        logic [oilws_pkg::COUNT_W-1:0]  item_count;
        logic [oilws_pkg::TOTAL_W-1:0]  total_weight;
    } answer_t;

    class list_scoreboard;
        logic [oilws_pkg::ID_W-1:0]     ids [oilws_pkg::CAPACITY_DEF];
        logic [oilws_pkg::WEIGHT_W-1:0] weights [oilws_pkg::CAPACITY_DEF];
        int unsigned                    held;
        int unsigned                    weight_total;
        answer_t                        awaited [$];
        int unsigned                    faults;

        function void note_request(logic [oilws_pkg::FUNC_W-1:0] func,
                                   logic [oilws_pkg::ID_W-1:0] id,
                                   logic [oilws_pkg::WEIGHT_W-1:0] wt,
                                   logic [oilws_pkg::POS_W-1:0] pos);
            answer_t ans;
            int unsigned i;
            ans = '0;
            ans.status = oilws_pkg::ST_DONE;
            if (func == oilws_pkg::FUNC_APPEND)
            begin
                if (held >= oilws_pkg::CAPACITY_DEF)
                    ans.status = oilws_pkg::ST_FULL;
                else
                begin
                    ids[held] = id;
                    weights[held] = wt;
                    held++;
                    weight_total += wt;
                end
            end
            else
            begin
                if (pos >= held)
                    ans.status = oilws_pkg::ST_BAD_INDEX;
                else
                begin
                    ans.removed_id = ids[pos];
                    ans.removed_weight = weights[pos];
                    for (i = pos; i + 1 < held; i++)
                    begin
                        ids[i] = ids[i + 1];
                        weights[i] = weights[i + 1];
                    end
                    held--;
                    weight_total -= ans.removed_weight;
                end
            end
            ans.item_count = oilws_pkg::COUNT_W'(held);
            ans.total_weight = (weight_total > oilws_pkg::TOTAL_MAX) ? oilws_pkg::TOTAL_MAX
                                                                     : oilws_pkg::TOTAL_W'(weight_total);
            awaited = {awaited, ans};
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                faults++;
            end
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (awaited.size() == 0)
            begin
                $error("response word with no request pending");
                faults++;
                return;
            end
            want = awaited.pop_front();
            compare("status", want.status, got.status);
            compare("removed_id", want.removed_id, got.removed_id);
            compare("removed_weight", want.removed_weight, got.removed_weight);
            compare("item_count", want.item_count, got.item_count);
            compare("total_weight", want.total_weight, got.total_weight);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    oilws_req_if req_ch ();
    oilws_rsp_if rsp_ch ();

    ordered_item_list_with_weight_sum_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_scoreboard board;
    bit             smooth;
    bit             squeeze_request;
    int             sink_stall;
    int             idle_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 0;
        if (r < 98)
            return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    task automatic offer(logic [oilws_pkg::FUNC_W-1:0] f, logic [oilws_pkg::ID_W-1:0] id,
                         logic [oilws_pkg::WEIGHT_W-1:0] wt,
                         logic [oilws_pkg::POS_W-1:0] pos);
        int gap;
        @(negedge clk);
        req_ch.func = f;
        req_ch.item_id = id;
        req_ch.item_weight = wt;
        req_ch.position = pos;
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(f, id, wt, pos);
        gap = smooth ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic random_word(phase_t phase);
        int                             r;
        logic [oilws_pkg::FUNC_W-1:0]   f;
        logic [oilws_pkg::WEIGHT_W-1:0] wt;
        logic [oilws_pkg::POS_W-1:0]    pos;
        r = $urandom_range(0, 99);
        case (phase)
            PH_GROW:   f = (r < 85) ? oilws_pkg::FUNC_APPEND : oilws_pkg::FUNC_REMOVE;
            PH_SHRINK: f = (r < 20) ? oilws_pkg::FUNC_APPEND : oilws_pkg::FUNC_REMOVE;
            default:   f = (r < 50) ? oilws_pkg::FUNC_APPEND : oilws_pkg::FUNC_REMOVE;
        endcase
        if ($urandom_range(0, 3) == 0)
            wt = oilws_pkg::WEIGHT_W'($urandom_range(16'hF000, 16'hFFFF));
        else
            wt = oilws_pkg::WEIGHT_W'($urandom);
        if (board.held > 0 && $urandom_range(0, 3) != 0)
            pos = oilws_pkg::POS_W'($urandom_range(0, board.held - 1));
        else
            pos = oilws_pkg::POS_W'($urandom_range(0, 31));
        offer(f, oilws_pkg::ID_W'($urandom), wt, pos);
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        sink_stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (squeeze_request)
            begin
                squeeze_request = 1'b0;
                sink_stall = SQUEEZE_CYCLES;
            end
            if (sink_stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                sink_stall--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                if (!smooth)
                    sink_stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_answer(answer_t'({rsp_ch.status, rsp_ch.removed_id,
                                          rsp_ch.removed_weight, rsp_ch.item_count,
                                          rsp_ch.total_weight}));
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        board = new();
        smooth = 1'b0;
        squeeze_request = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = oilws_pkg::FUNC_APPEND;
        req_ch.item_id = '0;
        req_ch.item_weight = '0;
        req_ch.position = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        offer(oilws_pkg::FUNC_REMOVE, 16'h0000, 16'h0000, 5'd0);
        offer(oilws_pkg::FUNC_REMOVE, 16'hFFFF, 16'hFFFF, 5'd31);
        offer(oilws_pkg::FUNC_APPEND, 16'h0000, 16'h0000, 5'd0);
        offer(oilws_pkg::FUNC_APPEND, 16'hFFFF, 16'hFFFF, 5'd31);
        offer(oilws_pkg::FUNC_APPEND, 16'h1234, 16'h8000, 5'd0);
        offer(oilws_pkg::FUNC_REMOVE, 16'h0000, 16'h0000, 5'd3);
        offer(oilws_pkg::FUNC_REMOVE, 16'h0000, 16'h0000, 5'd31);
        offer(oilws_pkg::FUNC_REMOVE, 16'h0000, 16'h0000, 5'd1);
        offer(oilws_pkg::FUNC_REMOVE, 16'h0000, 16'h0000, 5'd1);
        offer(oilws_pkg::FUNC_APPEND, 16'hA5A5, 16'h5A5A, 5'd0);
        offer(oilws_pkg::FUNC_REMOVE, 16'h0000, 16'h0000, 5'd0);
        offer(oilws_pkg::FUNC_REMOVE, 16'h0000, 16'h0000, 5'd0);
        offer(oilws_pkg::FUNC_REMOVE, 16'h0000, 16'h0000, 5'd0);

        squeeze_request = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            phase_t phase;
            if (n < PHASE_WORDS)
                phase = PH_GROW;
            else
                phase = phase_t'($urandom_range(0, 2));
            if (n % PHASE_WORDS == 0)
                smooth = ($urandom_range(0, 9) < 3);
            for (int k = 0; k < PHASE_WORDS && n < RANDOM_WORDS; k++, n++)
                random_word(phase);
            n--;
        end

        @(negedge clk);
        req_ch.valid = 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.faults == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
